/* design/cqf_pkg.sv */
// Shared types, widths and codes for the circular queue FIFO core.
// Used by the channel interfaces, the controller and the top level.
`timescale 1ns / 1ps

package cqf_pkg;

    // Storage depth used when the top level is not told otherwise.
    localparam int CQF_DEPTH_DEFAULT = 16;

    // Upper bound on the number of results that one display request may stream.
    localparam int CQF_MAX_RESULTS = 16;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;

    typedef logic [1:0]               op_t;
    typedef logic [1:0]               status_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // Operation codes of a request.
    localparam op_t OP_ENQ  = 2'd0;
    localparam op_t OP_DEQ  = 2'd1;
    localparam op_t OP_DISP = 2'd2;

    // Status codes of a result.
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    // Capacity after reset.
    localparam cnt_t CAP_RESET = 5'd16;

endpackage

/* design/cqf_if.sv */
// Valid/ready channel interfaces of the circular queue FIFO core: requests,
// results and the capacity register write. Depends on cqf_pkg.
`timescale 1ns / 1ps

interface cqf_req_if;
    logic          valid;
    logic          ready;
    cqf_pkg::op_t   op;
    cqf_pkg::data_t data;

    modport source (output valid, output op, output data, input ready);
    modport sink   (input valid, input op, input data, output ready);
endinterface

interface cqf_rsp_if;
    logic             valid;
    logic             ready;
    cqf_pkg::status_t status;
    cqf_pkg::data_t   value;
    logic             last;

    modport source (output valid, output status, output value, output last, input ready);
    modport sink   (input valid, input status, input value, input last, output ready);
endinterface

interface cqf_cfg_if;
    logic          valid;
    logic          ready;
    cqf_pkg::cnt_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/cqf_mem.sv */
// Slot storage of the circular queue FIFO: one write port and one read port
// with registered read data. Depends on cqf_pkg.
`timescale 1ns / 1ps

module cqf_mem #(
    parameter int DEPTH = cqf_pkg::CQF_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic           clk,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  cqf_pkg::data_t wr_data,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr,
    output cqf_pkg::data_t rd_data
);
    import cqf_pkg::*;

    data_t slot_mem [DEPTH];
    data_t rd_data_reg;

    // Read data holds its value until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/cqf_ctrl.sv */
// Queue controller: pointers, occupancy, capacity register, the walk over
// held entries and the result register. Depends on cqf_pkg and cqf_if.
`timescale 1ns / 1ps

module cqf_ctrl #(
    parameter int DEPTH = cqf_pkg::CQF_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic           clk,
    input  logic           rst_n,
    cqf_req_if.sink        req,
    cqf_rsp_if.source      rsp,
    cqf_cfg_if.sink        cfg,
    output logic           wr_en,
    output logic [AW-1:0]  wr_addr,
    output cqf_pkg::data_t wr_data,
    output logic           rd_en,
    output logic [AW-1:0]  rd_addr,
    input  cqf_pkg::data_t rd_data
);
    import cqf_pkg::*;

    localparam int   CAP_LIM_INT = (DEPTH < CQF_MAX_RESULTS) ? DEPTH : CQF_MAX_RESULTS;
    localparam cnt_t CAP_LIM     = CNT_W'(CAP_LIM_INT);
    localparam cnt_t CNT_ONE     = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    cap_reg, cap_next;
    cnt_t    head_reg, head_next;
    cnt_t    tail_reg, tail_next;
    cnt_t    occ_reg, occ_next;
    cnt_t    walk_ptr_reg, walk_ptr_next;
    cnt_t    walk_left_reg, walk_left_next;
    logic    out_valid_reg, out_valid_next;
    status_t out_status_reg, out_status_next;
    data_t   out_value_reg, out_value_next;
    logic    out_last_reg, out_last_next;

    cnt_t cap_eff;
    logic out_free;
    logic accept;
    logic q_full;
    logic q_empty;

    // Step a pointer by one, wrapping at the effective capacity.
    function automatic cnt_t step_ptr(input cnt_t ptr, input cnt_t cap);
        cnt_t n;
        n = ptr + CNT_ONE;
        return (n >= cap) ? '0 : n;
    endfunction

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_ONE;
        end
        else if (cap_reg > CAP_LIM)
        begin
            cap_eff = CAP_LIM;
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign q_full    = (occ_reg >= cap_eff);
    assign q_empty   = (occ_reg == '0);
    assign cfg.ready = 1'b1;

    assign wr_data = req.data;
    assign wr_addr = AW'(tail_reg);

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        walk_ptr_next   = walk_ptr_reg;
        walk_left_next  = walk_left_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = AW'(head_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.op) inside
                        OP_ENQ:
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            if (q_full)
                            begin
                                out_status_next = STATUS_FULL;
                                out_value_next  = '0;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                tail_next       = step_ptr(tail_reg, cap_eff);
                                occ_next        = occ_reg + CNT_ONE;
                                out_status_next = STATUS_OK;
                                out_value_next  = req.data;
                            end
                        end
                        OP_DEQ, OP_DISP:
                        begin
                            if (q_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_last_next   = 1'b1;
                                out_status_next = STATUS_EMPTY;
                                out_value_next  = '0;
                            end
                            else
                            begin
                                rd_en         = 1'b1;
                                walk_ptr_next = step_ptr(head_reg, cap_eff);
                                state_next    = ST_READ;
                                if (req.op == OP_DEQ)
                                begin
                                    head_next      = step_ptr(head_reg, cap_eff);
                                    occ_next       = occ_reg - CNT_ONE;
                                    walk_left_next = CNT_ONE;
                                end
                                else
                                begin
                                    walk_left_next = occ_reg;
                                end
                            end
                        end
                        default:
                        begin
                            // The spare operation code is dropped without a result.
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_value_next  = rd_data;
                    out_last_next   = (walk_left_reg == CNT_ONE);
                    if (walk_left_reg == CNT_ONE)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = AW'(walk_ptr_reg);
                        walk_ptr_next  = step_ptr(walk_ptr_reg, cap_eff);
                        walk_left_next = walk_left_reg - CNT_ONE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A capacity write empties the queue.
        if (cfg.valid)
        begin
            cap_next  = cfg.data;
            head_next = '0;
            tail_next = '0;
            occ_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            walk_ptr_reg  <= '0;
            walk_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            walk_ptr_reg  <= walk_ptr_next;
            walk_left_reg <= walk_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.last   = out_last_reg;

endmodule

/* design/circular_queue_fifo_core.sv */
// Top level of the circular queue FIFO core: the slot memory and the queue
// controller. Depends on cqf_pkg, cqf_if, cqf_mem and cqf_ctrl.
`timescale 1ns / 1ps

// A circular FIFO of signed 32-bit words whose usable capacity is set by the
// capacity register (1 to the smaller of DEPTH and 16; zero counts as one and
// larger values saturate). Each request transfer on req carries an operation:
// an enqueue gives one result that echoes the stored word or reports full; a
// dequeue gives the oldest word or reports empty; a display streams every held
// word from oldest to newest, with last set on the newest, and reports empty
// once if nothing is held. Every request yields its results in order on rsp,
// each with last set on the final one; the spare operation code gives none.
// Timing: an enqueue, and any request on an empty queue, has its result
// registered in the cycle it is accepted; a dequeue or a display reads its
// words from a single memory read port with registered read data, and they
// come one per cycle while the result register is free or being emptied. A
// new request is taken once the previous one has finished and the result
// register is free or being emptied in the same cycle. A capacity write
// empties the queue and should be made only while no request is in progress.
module circular_queue_fifo_core #(
    parameter int DEPTH = cqf_pkg::CQF_DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    cqf_req_if.sink   req,
    cqf_rsp_if.source rsp,
    cqf_cfg_if.sink   cfg
);
    import cqf_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    data_t         wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    data_t         rd_data;

    // Slot storage, written on enqueue and read on dequeue and display.
    cqf_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pointer, occupancy and result handling.
    cqf_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .cfg     (cfg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

/* tb/sv/circular_queue_fifo_core_test.sv */
// Self-checking testbench for circular_queue_fifo_core: drives requests and capacity writes,
// predicts every result and checks each one as it is transferred. Depends on cqf_pkg and the
// channel interfaces in cqf_if.
`timescale 1ns / 1ps

module circular_queue_fifo_core_test;

    import cqf_pkg::*;

    // The spare operation code: the block must ignore it and give no result.
    localparam op_t OP_SPARE = 2'd3;

    // The block is instantiated with its default depth.
    localparam int QUEUE_DEPTH = CQF_DEPTH_DEFAULT;

    // Cycles allowed after the last owed result before the block counts as idle.
    localparam int SETTLE_CYCLES = 24;

    // Length of the deliberate receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES = 150;

    // Cycles without any transfer on any channel before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;

    // Only the first 200 mismatches are printed; all are counted.
    localparam int REPORT_LINES = 200;

    // One result as the block should present it.
    typedef struct {
        status_t status;
        data_t   value;
        logic    last;
    } queue_result_t;

    // Mirror of the queue: its own slots, indices, occupancy and capacity register, plus the
    // results still owed by the block, oldest first.
    class queue_tracker;
        data_t         slot_mem[QUEUE_DEPTH];
        int unsigned   head;
        int unsigned   tail;
        int unsigned   held;
        cnt_t          capacity;
        queue_result_t owed[$];

        function new();
            capacity = CAP_RESET;
            head     = 0;
            tail     = 0;
            held     = 0;
        endfunction

        // Register value saturated to 1 .. min(depth, result limit); zero counts as one.
        function int unsigned usable_slots();
            int unsigned ceiling;
            int unsigned slots;
            ceiling = (QUEUE_DEPTH < CQF_MAX_RESULTS) ? QUEUE_DEPTH : CQF_MAX_RESULTS;
            slots   = capacity;
            if (slots < 1)
                slots = 1;
            if (slots > ceiling)
                slots = ceiling;
            return slots;
        endfunction

        function int unsigned wrap_next(int unsigned idx, int unsigned slots);
            return (idx + 1 >= slots) ? 0 : idx + 1;
        endfunction

        function void owe(status_t status, data_t value, logic last);
            queue_result_t item;
            item.status = status;
            item.value  = value;
            item.last   = last;
            owed.push_back(item);
        endfunction

        // A capacity write also empties the queue; the old words stay but are unreachable.
        function void write_capacity(cnt_t setting);
            capacity = setting;
            head     = 0;
            tail     = 0;
            held     = 0;
        endfunction

        // Called for each accepted request: updates the mirror and queues the owed results.
        function void note_request(op_t op, data_t word);
            int unsigned slots;
            int unsigned idx;
            slots = usable_slots();
            case (op)
                OP_ENQ:
                begin
                    if (held >= slots)
                    begin
                        owe(STATUS_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        slot_mem[tail] = word;
                        tail = wrap_next(tail, slots);
                        held++;
                        owe(STATUS_OK, word, 1'b1);
                    end
                end
                OP_DEQ:
                begin
                    if (held == 0)
                    begin
                        owe(STATUS_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        owe(STATUS_OK, slot_mem[head], 1'b1);
                        head = wrap_next(head, slots);
                        held--;
                    end
                end
                OP_DISP:
                begin
                    if (held == 0)
                    begin
                        owe(STATUS_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        idx = head;
                        for (int unsigned k = 0; k < held && k < CQF_MAX_RESULTS; k++)
                        begin
                            owe(STATUS_OK, slot_mem[idx], (k + 1 == held));
                            idx = wrap_next(idx, slots);
                        end
                    end
                end
                default:
                begin
                    // The spare code changes nothing and owes nothing.
                end
            endcase
        endfunction

        // Compares one transferred result with the oldest owed one. Returns an empty string
        // when it matches, otherwise a description of what went wrong.
        function string check_result(status_t status, data_t value, logic last);
            queue_result_t want;
            string         diff;
            if (owed.size() == 0)
                return $sformatf("result with nothing owed: status %0d value %0d last %0b",
                                 status, value, last);
            want = owed.pop_front();
            diff = "";
            if (status !== want.status)
                diff = {diff, $sformatf(" status %0d/%0d", status, want.status)};
            if (value !== want.value)
                diff = {diff, $sformatf(" value %0d/%0d", value, want.value)};
            if (last !== want.last)
                diff = {diff, $sformatf(" last %0b/%0b", last, want.last)};
            if (diff != "")
                diff = {"result differs (got/expected):", diff};
            return diff;
        endfunction

        function int unsigned pending();
            return owed.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cqf_req_if req_ch ();
    cqf_rsp_if rsp_ch ();
    cqf_cfg_if cfg_ch ();

    queue_tracker book = new();

    int unsigned mismatches = 0;
    int unsigned rsp_hold_cycles = 0;  // set by the stimulus, consumed by the receiver
    bit          req_paced = 1'b1;     // when clear the sender offers items back to back

    circular_queue_fifo_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LINES)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // Gap lengths: half the time none, mostly a few cycles, now and then a long pause.
    function automatic int unsigned pick_pause(input bit paced);
        int unsigned roll;
        if (!paced)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Words are biased towards the extremes of the signed range.
    function automatic data_t pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return data_t'(32'h8000_0000);
            2:       return '0;
            3:       return '1;
            default: return data_t'($urandom);
        endcase
    endfunction

    // Presents one request from the next falling edge and returns at the rising edge on which
    // it is transferred. Valid is left high so that a following request can go back to back.
    task automatic send_request(input op_t op, input data_t word);
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.data  <= word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic idle_requests(input int unsigned cycles);
        if (cycles != 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    task automatic offer(input op_t op, input data_t word);
        idle_requests(pick_pause(req_paced));
        send_request(op, word);
    endtask

    // Stops offering requests and waits until every owed result has been transferred, then
    // gives the block time to finish any request that owed nothing.
    task automatic settle_queue();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_capacity(input cnt_t setting);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= setting;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random traffic in runs that either tend to fill the queue or tend to drain it, with
    // displays and the odd spare code mixed in. Spare codes do not count towards the total.
    task automatic random_phase(input int unsigned items);
        int unsigned done;
        int unsigned run_left;
        int unsigned roll;
        bit          filling;
        op_t         op;
        done     = 0;
        run_left = 0;
        filling  = 1'b1;
        while (done < items)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(6, 30);
                filling  = $urandom_range(0, 1);
            end
            run_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = OP_SPARE;
            else if (roll < 15)
                op = OP_DISP;
            else if (roll < (filling ? 75 : 37))
                op = OP_ENQ;
            else
                op = OP_DEQ;
            offer(op, pick_word());
            if (op != OP_SPARE)
                done++;
        end
    endtask

    // Receiver: bursts of readiness broken by gaps, and a long hold-off when the stimulus
    // asks for one. The hold-off is counted here so that the sender keeps offering meanwhile.
    initial
    begin : receiver
        int unsigned span;
        rsp_ch.ready = 1'b0;
        forever
        begin
            if (rsp_hold_cycles != 0)
            begin
                span = rsp_hold_cycles;
                rsp_hold_cycles = 0;
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
                repeat (span - 1)
                    @(negedge clk);
            end
            else
            begin
                span = $urandom_range(1, 24);
                @(negedge clk);
                rsp_ch.ready <= 1'b1;
                repeat (span - 1)
                    @(negedge clk);
                span = pick_pause(1'b1);
                if (span != 0)
                begin
                    @(negedge clk);
                    rsp_ch.ready <= 1'b0;
                    repeat (span - 1)
                        @(negedge clk);
                end
            end
        end
    end

    // Everything is sampled at the rising edge, after the inputs last changed on the falling edge.
    // A capacity write and a request never share an edge, since writes are made only while
    // the block is idle.
    always @(posedge clk)
    begin : monitor
        string msg;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                book.write_capacity(cfg_ch.data);
            if (req_ch.valid && req_ch.ready)
                book.note_request(req_ch.op, req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                msg = book.check_result(rsp_ch.status, rsp_ch.value, rsp_ch.last);
                if (msg != "")
                    report_mismatch(msg);
            end
        end
    end

    // Watchdog: the run is declared hung when no transfer of any kind happens for too long.
    // This also catches results that are owed but never arrive.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d results still owed",
                 QUIET_LIMIT, book.pending());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        cnt_t settings[9];

        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_ENQ;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;

        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset capacity: requests on an empty queue, the spare code,
        // the extremes of the word range, and displays around dequeues.
        offer(OP_DISP, '0);
        offer(OP_DEQ, '1);
        offer(OP_SPARE, 32'sh1234_5678);
        offer(OP_ENQ, 32'sh7FFF_FFFF);
        offer(OP_ENQ, data_t'(32'h8000_0000));
        offer(OP_ENQ, '0);
        offer(OP_ENQ, '1);
        offer(OP_ENQ, 32'sh5555_5555);
        offer(OP_ENQ, data_t'(32'hAAAA_AAAA));
        offer(OP_DISP, '0);
        offer(OP_DEQ, '0);
        offer(OP_DEQ, '0);
        offer(OP_DISP, '0);

        // A small capacity: the write empties the queue, then full, wrap-around of both
        // indices, and empty again.
        settle_queue();
        write_capacity(5'd2);
        offer(OP_ENQ, 32'sd11);
        offer(OP_ENQ, -32'sd22);
        offer(OP_ENQ, 32'sd33);
        offer(OP_DISP, '0);
        offer(OP_DEQ, '0);
        offer(OP_ENQ, -32'sd44);
        offer(OP_DISP, '0);
        offer(OP_DEQ, '0);
        offer(OP_DEQ, '0);
        offer(OP_DEQ, '0);
        offer(OP_DISP, '0);

        // Random phases over a range of capacities: zero (counts as one), the top of the
        // register (saturates), one, the full depth and a few in between.
        settings[0] = 5'd0;
        settings[1] = 5'd31;
        settings[2] = 5'd1;
        settings[3] = 5'd16;
        settings[4] = 5'd2;
        settings[5] = cnt_t'($urandom_range(3, 15));
        settings[6] = cnt_t'($urandom_range(0, 31));
        settings[7] = 5'd16;
        settings[8] = 5'd7;

        foreach (settings[p])
        begin
            settle_queue();
            write_capacity(settings[p]);
            req_paced = ($urandom_range(0, 3) != 0);
            if (p == 7)
            begin
                // Hold the receiver off while requests keep coming, so that the result
                // register stays occupied and the block has to stall its request channel.
                req_paced = 1'b0;
                rsp_hold_cycles = HOLD_CYCLES;
            end
            random_phase(50);
        end

        settle_queue();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* circular_queue_fifo_core.f */
design/cqf_pkg.sv
design/cqf_if.sv
design/cqf_mem.sv
design/cqf_ctrl.sv
design/circular_queue_fifo_core.sv
tb/sv/circular_queue_fifo_core_test.sv
